// ===== rtl/core/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types, sizes, codes and helpers of the chemical formula parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam int TABLE_SLOTS  = 16;
	localparam int SYMBOL_CHARS = 3;
	localparam int COUNT_BITS   = 16;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int USED_W = $clog2(TABLE_SLOTS + 1);
	localparam int SYM_W  = 8 * SYMBOL_CHARS;
	localparam int LEN_W  = $clog2(SYMBOL_CHARS + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// queues between the parts, power-of-two depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic RK_TERM   = 1'b0;
	localparam logic RK_STATUS = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_BADCHAR = 3'd2;
	localparam logic [2:0] ST_NOELEM  = 3'd3;
	localparam logic [2:0] ST_LONG    = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef enum logic [2:0] {
		PH_START  = 3'b001,
		PH_SYMBOL = 3'b010,
		PH_COUNT  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [23:0] symbol;
		logic [15:0] term_count;
		logic [15:0] total_count;
		logic [3:0]  slot;
		logic [2:0]  status;
		logic        last_of_run;
	} out_word_t;

	// work handed from the front part to the back part
	typedef struct packed {
		logic                  is_end;
		logic                  has_term;
		logic [2:0]            err;
		logic                  seen;
		logic [SYM_W-1:0]      symbol;
		logic [COUNT_BITS-1:0] count;
	} op_t;

	// top three bytes of the symbol, zero padded for short symbols
	function automatic logic [23:0] show_symbol(input logic [SYM_W-1:0] sym);
		logic [SYM_W+23:0] ext;
		ext = {sym, 24'h0};
		return ext[SYM_W+23 -: 24];
	endfunction

	function automatic logic [15:0] clip_count(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+15:0] ext;
		ext = {16'h0, v};
		if (ext > (COUNT_BITS+16)'(16'hFFFF))
			return 16'hFFFF;
		return ext[15:0];
	endfunction

endpackage

// ===== rtl/core/cfp_opq.sv =====
// ----------------------------------------------------------------------------
// cfp_opq
// Short queue of parsed operations between the front and back parts.
// ----------------------------------------------------------------------------
module cfp_opq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cfp_pkg::op_t wdata,
	output logic         full,
	input  logic         pop,
	output cfp_pkg::op_t rdata,
	output logic         empty
);
	import cfp_pkg::*;

	op_t               mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/cfp_resq.sv =====
// ----------------------------------------------------------------------------
// cfp_resq
// Result queue that decouples the back part from the consumer.
// ----------------------------------------------------------------------------
module cfp_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cfp_pkg::out_word_t wdata,
	output logic               full,
	input  logic               pop,
	output cfp_pkg::out_word_t rdata,
	output logic               empty
);
	import cfp_pkg::*;

	out_word_t         mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/cfp_front.sv =====
// ----------------------------------------------------------------------------
// cfp_front
// Character classifier and term tokenizer; hands completed terms, errors
// and end marks to the back part.
// ----------------------------------------------------------------------------
module cfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfp_pkg::in_word_t item,
	output logic              full,
	output logic              op_push,
	output cfp_pkg::op_t      op,
	input  logic              op_full
);
	import cfp_pkg::*;

	phase_t                phase_q, phase_d;
	logic [2:0]            err_q, err_d;
	logic                  seen_q, seen_d;
	logic [SYM_W-1:0]      buf_q, buf_d;
	logic [LEN_W-1:0]      len_q, len_d;
	logic [COUNT_BITS-1:0] acc_q, acc_d;

	logic                  accept;
	logic                  is_space, is_upper, is_lower, is_digit;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [COUNT_BITS+3:0] acc_prod;
	logic [COUNT_BITS-1:0] acc_next;
	logic [SYM_W-1:0]      ins;

	assign full   = op_full;
	assign accept = push && !op_full;

	assign is_space = (item.ch == 8'd32) || (item.ch >= 8'd9 && item.ch <= 8'd13);
	assign is_upper = (item.ch >= 8'd65) && (item.ch <= 8'd90);
	assign is_lower = (item.ch >= 8'd97) && (item.ch <= 8'd122);
	assign is_digit = (item.ch >= 8'd48) && (item.ch <= 8'd57);

	// missing count or zero count means one
	assign cnt_eff = (acc_q == '0) ? COUNT_BITS'(1) : acc_q;

	// decimal accumulate, saturating
	assign acc_prod = {4'h0, acc_q} * (COUNT_BITS+4)'(10)
		+ (COUNT_BITS+4)'(item.ch - 8'd48);
	assign acc_next = (acc_prod > {4'h0, COUNT_MAX}) ? COUNT_MAX
		: acc_prod[COUNT_BITS-1:0];

	// lowercase letter placed at the next free byte
	always_comb begin
		ins = '0;
		for (int i = 0; i < SYMBOL_CHARS; i++) begin
			if (LEN_W'(SYMBOL_CHARS - 1 - i) == len_q)
				ins[i*8 +: 8] = item.ch;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		err_d       = err_q;
		seen_d      = seen_q;
		buf_d       = buf_q;
		len_d       = len_q;
		acc_d       = acc_q;
		op_push     = 1'b0;
		op          = '0;
		op.symbol   = buf_q;
		op.count    = cnt_eff;
		op.seen     = seen_q;
		if (accept) begin
			if (item.kind == KIND_END) begin
				op_push     = 1'b1;
				op.is_end   = 1'b1;
				op.has_term = (err_q == ST_OK) && (phase_q != PH_START);
				phase_d     = PH_START;
				err_d       = ST_OK;
				seen_d      = 1'b0;
				buf_d       = '0;
				len_d       = '0;
				acc_d       = '0;
			end else begin
				seen_d = 1'b1;
				if (err_q == ST_OK) begin
					if (phase_q == PH_SYMBOL && is_lower) begin
						if (len_q >= LEN_W'(SYMBOL_CHARS)) begin
							err_d   = ST_LONG;
							op.err  = ST_LONG;
							op_push = 1'b1;
						end else begin
							buf_d = buf_q | ins;
							len_d = len_q + 1'b1;
						end
					end else if (phase_q != PH_START && is_digit) begin
						acc_d   = acc_next;
						phase_d = PH_COUNT;
					end else begin
						// anything else closes the pending term; an uppercase letter then starts a new one
						op.has_term = (phase_q != PH_START);
						phase_d     = PH_START;
						if (!is_space) begin
							if (!is_upper) begin
								err_d  = ST_BADCHAR;
								op.err = ST_BADCHAR;
							end else begin
								buf_d                 = '0;
								buf_d[SYM_W-1 -: 8]   = item.ch;
								len_d                 = LEN_W'(1);
								acc_d                 = '0;
								phase_d               = PH_SYMBOL;
							end
						end
						op_push = (phase_q != PH_START) || (!is_space && !is_upper);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			err_q   <= ST_OK;
			seen_q  <= 1'b0;
			buf_q   <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			err_q   <= err_d;
			seen_q  <= seen_d;
			buf_q   <= buf_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ===== rtl/core/cfp_back.sv =====
// ----------------------------------------------------------------------------
// cfp_back
// Symbol table: merges completed terms, tracks the formula status and
// builds the result words.
// ----------------------------------------------------------------------------
module cfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  cfp_pkg::op_t       op,
	input  logic               op_valid,
	output logic               op_pop,
	output logic               res_push,
	output cfp_pkg::out_word_t res,
	input  logic               res_full
);
	import cfp_pkg::*;

	logic [SYM_W-1:0]      sym_q [TABLE_SLOTS];
	logic [COUNT_BITS-1:0] tot_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [USED_W-1:0]     used_q;
	logic [2:0]            err_q;
	logic                  sub_q;

	logic                  go;
	logic                  do_term;
	logic                  term_ok;
	logic                  end_two;
	logic [TABLE_SLOTS-1:0] hit;
	logic                  hit_any;
	logic [SLOT_W-1:0]     found;
	logic                  tab_full;
	logic [SLOT_W-1:0]     slot_sel;
	logic [COUNT_BITS:0]   sum;
	logic [COUNT_BITS-1:0] new_tot;
	logic [SLOT_W+3:0]     slot_ext;
	logic [2:0]            err_after;
	logic [2:0]            st;
	logic                  do_status;

	assign go       = op_valid && !res_full;
	assign do_term  = op.has_term && !sub_q && (err_q == ST_OK);
	assign end_two  = op.is_end && do_term;

	// parallel compare against every slot
	always_comb begin
		hit   = '0;
		found = '0;
		for (int i = 0; i < TABLE_SLOTS; i++)
			hit[i] = valid_q[i] && (sym_q[i] == op.symbol);
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (hit[i])
				found = SLOT_W'(i);
		end
	end

	assign hit_any  = |hit;
	assign tab_full = (used_q == USED_W'(TABLE_SLOTS));
	assign term_ok  = do_term && (hit_any || !tab_full);
	assign slot_sel = hit_any ? found : used_q[SLOT_W-1:0];

	assign sum      = {1'b0, tot_q[found]} + {1'b0, op.count};
	assign new_tot  = !hit_any ? op.count
		: (sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0]);
	assign slot_ext = {4'h0, slot_sel};

	// a full table takes priority over an error raised by the same character
	always_comb begin
		err_after = err_q;
		if (do_term && !term_ok)
			err_after = ST_FULL;
		if (!op.is_end && err_after == ST_OK && op.err != ST_OK)
			err_after = op.err;
	end

	always_comb begin
		if (err_q != ST_OK)
			st = err_q;
		else if (!op.seen)
			st = ST_EMPTY;
		else if (used_q == '0)
			st = ST_NOELEM;
		else
			st = ST_OK;
	end

	assign do_status = op.is_end && !end_two;
	assign op_pop    = go && !end_two;
	assign res_push  = go && (term_ok || do_status);

	always_comb begin
		res = '0;
		if (term_ok) begin
			res.result_kind = RK_TERM;
			res.symbol      = show_symbol(op.symbol);
			res.term_count  = clip_count(op.count);
			res.total_count = clip_count(new_tot);
			res.slot        = slot_ext[3:0];
			res.status      = ST_OK;
			res.last_of_run = !op.is_end;
		end else begin
			res.result_kind = RK_STATUS;
			res.status      = st;
			res.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && term_ok) begin
			sym_q[slot_sel] <= op.symbol;
			tot_q[slot_sel] <= new_tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			err_q   <= ST_OK;
			sub_q   <= 1'b0;
		end else if (go) begin
			if (do_status) begin
				// end of formula: table and status start over
				valid_q <= '0;
				used_q  <= '0;
				err_q   <= ST_OK;
				sub_q   <= 1'b0;
			end else begin
				err_q <= err_after;
				if (end_two)
					sub_q <= 1'b1;
				if (term_ok && !hit_any) begin
					valid_q[slot_sel] <= 1'b1;
					used_q            <= used_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/chemical_formula_parser.sv =====
// A term result is registered in the operation queue and then in the result queue.
// An end word that closes a pending term gives the term word and then the status word.
// Throughput: one word per cycle while full is low; the table stage handles an end word with a
// pending term once for the term and once for the status. All slots are compared in parallel.
// Reset: arst_n clears the parser state, the table valid bits and both queues; no clearing pass.
// ----------------------------------------------------------------------------
// chemical_formula_parser
// Parses a flat chemical formula one character per word and reports each
// term with its merged total, then a final status per formula.
// ----------------------------------------------------------------------------
module chemical_formula_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cfp_pkg::in_word_t  item,
	output logic               empty,
	input  logic               pop,
	output cfp_pkg::out_word_t result
);
	import cfp_pkg::*;

	logic      op_push;
	op_t       op_in;
	logic      op_full;
	op_t       op_head;
	logic      op_empty;
	logic      op_pop;
	logic      res_push;
	out_word_t res_word;
	logic      res_full;

	cfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.op_push (op_push),
		.op      (op_in),
		.op_full (op_full)
	);

	cfp_opq u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_in),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_head),
		.empty  (op_empty)
	);

	cfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op_head),
		.op_valid (!op_empty),
		.op_pop   (op_pop),
		.res_push (res_push),
		.res      (res_word),
		.res_full (res_full)
	);

	cfp_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_word),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result word pushed into a full result queue");

	a_op_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		op_pop |-> !op_empty)
		else $error("operation popped from an empty queue");

	a_term_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_word.result_kind == RK_TERM) |->
			(res_word.term_count != 16'h0 && res_word.total_count >= res_word.term_count))
		else $error("term word with a zero count or a total below its count");

	a_end_two_words: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_word.result_kind == RK_TERM && !res_word.last_of_run) |=>
			!op_empty)
		else $error("end word left the queue before its status word");

endmodule

// ===== tb/chemical_formula_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chemical_formula_parser_tb
// Streams formulas into the parser: a short table of directed words, then
// random well-formed, crowded, broken and noisy formulas. Every result word
// is checked field by field against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module chemical_formula_parser_tb;
	import cfp_pkg::*;

	localparam int WORD_TARGET = 1400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP   = 100;

	typedef struct packed {
		in_word_t   w;
		logic       fixed;
		logic [2:0] st;
	} dir_row_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_word_t  item   = '0;
	logic      full;
	logic      empty;
	out_word_t result;

	// parser model state
	phase_t                ph;
	logic [2:0]            err;
	bit                    seen;
	logic [SYM_W-1:0]      sbuf;
	int                    slen;
	logic [COUNT_BITS-1:0] acc;
	logic [SYM_W-1:0]      tab_sym [TABLE_SLOTS];
	logic [COUNT_BITS-1:0] tab_tot [TABLE_SLOTS];
	bit [TABLE_SLOTS-1:0]  tab_ok;
	int                    used;

	out_word_t awaited[$];
	in_word_t  formula[$];
	dir_row_t  dir_rows[$];
	int        mismatches = 0;
	int        words_in   = 0;
	int        live_words = 0;
	int        cycles     = 0;
	bit        calm       = 1'b0;

	chemical_formula_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_word(input out_word_t got, input out_word_t want);
		if (got.result_kind !== want.result_kind)
			report_mismatch($sformatf("result_kind %0h, want %0h", got.result_kind,
				want.result_kind));
		if (got.symbol !== want.symbol)
			report_mismatch($sformatf("symbol %h, want %h", got.symbol, want.symbol));
		if (got.term_count !== want.term_count)
			report_mismatch($sformatf("term_count %0d, want %0d", got.term_count,
				want.term_count));
		if (got.total_count !== want.total_count)
			report_mismatch($sformatf("total_count %0d, want %0d", got.total_count,
				want.total_count));
		if (got.slot !== want.slot)
			report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.last_of_run !== want.last_of_run)
			report_mismatch($sformatf("last_of_run %0h, want %0h", got.last_of_run,
				want.last_of_run));
	endtask

	function automatic void clear_parser();
		ph     = PH_START;
		err    = ST_OK;
		seen   = 1'b0;
		sbuf   = '0;
		slen   = 0;
		acc    = '0;
		tab_ok = '0;
		used   = 0;
	endfunction

	function automatic logic [15:0] to_field16(input logic [COUNT_BITS-1:0] v);
		return (32'(v) > 32'hFFFF) ? 16'hFFFF : 16'(v);
	endfunction

	function automatic out_word_t status_word(input logic [2:0] st);
		out_word_t w;
		w             = '0;
		w.result_kind = RK_STATUS;
		w.status      = st;
		w.last_of_run = 1'b1;
		return w;
	endfunction

	// merge the pending term into the symbol table
	function automatic bit close_term(output out_word_t t);
		logic [COUNT_BITS-1:0] cnt;
		logic [COUNT_BITS:0]   sum;
		logic [SYM_W+23:0]     wide;
		int                    hit;
		int                    i;
		t   = '0;
		cnt = (acc == '0) ? COUNT_BITS'(1) : acc;
		ph  = PH_START;
		hit = -1;
		for (i = TABLE_SLOTS - 1; i >= 0; i--)
			if (tab_ok[i] && tab_sym[i] == sbuf)
				hit = i;
		if (hit < 0) begin
			if (used >= TABLE_SLOTS) begin
				err = ST_FULL;
				return 1'b0;
			end
			hit          = used;
			tab_sym[hit] = sbuf;
			tab_tot[hit] = cnt;
			tab_ok[hit]  = 1'b1;
			used++;
		end else begin
			sum          = {1'b0, tab_tot[hit]} + cnt;
			tab_tot[hit] = sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
		end
		wide          = {sbuf, 24'h0} >> SYM_W;
		t.result_kind = RK_TERM;
		t.symbol      = wide[23:0];
		t.term_count  = to_field16(cnt);
		t.total_count = to_field16(tab_tot[hit]);
		t.slot        = 4'(hit);
		t.status      = ST_OK;
		t.last_of_run = 1'b1;
		return 1'b1;
	endfunction

	// returns 0 when the word is swallowed by a sticky error
	function automatic bit parse_word(input in_word_t w);
		out_word_t   t;
		logic [2:0]  st;
		logic [7:0]  c;
		int unsigned grown;
		bit          made;
		c    = w.ch;
		made = 1'b0;
		if (w.kind == KIND_END) begin
			if (err == ST_OK && ph != PH_START)
				made = close_term(t);
			if (err != ST_OK)
				st = err;
			else if (!seen)
				st = ST_EMPTY;
			else if (used == 0)
				st = ST_NOELEM;
			else
				st = ST_OK;
			if (made) begin
				t.last_of_run = 1'b0;
				awaited.push_back(t);
			end
			awaited.push_back(status_word(st));
			clear_parser();
			return 1'b1;
		end
		seen = 1'b1;
		if (err != ST_OK)
			return 1'b0;
		if (ph == PH_SYMBOL && c >= "a" && c <= "z") begin
			if (slen >= SYMBOL_CHARS) begin
				err = ST_LONG;
			end else begin
				sbuf |= SYM_W'(c) << (8 * (SYMBOL_CHARS - 1 - slen));
				slen++;
			end
			return 1'b1;
		end
		if (ph != PH_START && c >= "0" && c <= "9") begin
			grown = 32'(acc) * 10 + 32'(c) - 32'd48;
			acc   = (grown > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(grown);
			ph    = PH_COUNT;
			return 1'b1;
		end
		if (ph != PH_START) begin
			if (close_term(t))
				awaited.push_back(t);
		end
		if (err == ST_OK && !(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
			if (c < "A" || c > "Z") begin
				err = ST_BADCHAR;
			end else begin
				sbuf = SYM_W'(c) << (8 * (SYMBOL_CHARS - 1));
				slen = 1;
				acc  = '0;
				ph   = PH_SYMBOL;
			end
		end
		return 1'b1;
	endfunction

	function automatic void add_row(input logic kind, input logic [7:0] c, input logic fixed,
		input logic [2:0] st);
		dir_row_t r;
		r.w.kind = kind;
		r.w.ch   = c;
		r.fixed  = fixed;
		r.st     = st;
		dir_rows.push_back(r);
	endfunction

	function automatic void put_char(input logic [7:0] c);
		in_word_t w;
		w.kind = KIND_CHAR;
		w.ch   = c;
		formula.push_back(w);
	endfunction

	function automatic logic [7:0] pick_space();
		int s;
		s = $urandom_range(0, 5);
		return (s == 0) ? 8'd32 : 8'(8 + s);
	endfunction

	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(99) < 7) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		words_in++;
		if (parse_word(w))
			live_words++;
	endtask

	initial begin : stimulus
		int       pick;
		int       nterms;
		int       i;
		in_word_t w;
		clear_parser();

		add_row(KIND_END,  8'h00, 1'b1, ST_EMPTY);
		add_row(KIND_CHAR, " ",   1'b0, ST_OK);
		add_row(KIND_END,  8'h00, 1'b1, ST_NOELEM);
		add_row(KIND_CHAR, "7",   1'b0, ST_OK);
		add_row(KIND_END,  8'h00, 1'b1, ST_BADCHAR);
		add_row(KIND_CHAR, "H",   1'b0, ST_OK);
		add_row(KIND_CHAR, "e",   1'b0, ST_OK);
		add_row(KIND_CHAR, "x",   1'b0, ST_OK);
		add_row(KIND_CHAR, "y",   1'b0, ST_OK);
		add_row(KIND_END,  8'h00, 1'b1, ST_LONG);
		// count saturates, then zero count and tab end a term, total stays saturated
		add_row(KIND_CHAR, "C",   1'b0, ST_OK);
		add_row(KIND_CHAR, "9",   1'b0, ST_OK);
		add_row(KIND_CHAR, "9",   1'b0, ST_OK);
		add_row(KIND_CHAR, "9",   1'b0, ST_OK);
		add_row(KIND_CHAR, "9",   1'b0, ST_OK);
		add_row(KIND_CHAR, "9",   1'b0, ST_OK);
		add_row(KIND_CHAR, "O",   1'b0, ST_OK);
		add_row(KIND_CHAR, "0",   1'b0, ST_OK);
		add_row(KIND_CHAR, 8'd9,  1'b0, ST_OK);
		add_row(KIND_CHAR, "C",   1'b0, ST_OK);
		add_row(KIND_CHAR, "2",   1'b0, ST_OK);
		add_row(KIND_END,  8'h00, 1'b0, ST_OK);
		add_row(KIND_CHAR, 8'hFF, 1'b0, ST_OK);
		add_row(KIND_END,  8'hFF, 1'b1, ST_BADCHAR);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			send_word(dir_rows[r].w);
			if (dir_rows[r].fixed) begin
				void'(awaited.pop_back());
				awaited.push_back(status_word(dir_rows[r].st));
			end
		end

		while (live_words < WORD_TARGET) begin
			calm = (words_in >= 700 && words_in < 1000);
			formula.delete();
			pick = $urandom_range(99);
			if (pick < 65) begin
				// well formed, small symbol pool so terms merge
				if ($urandom_range(3) == 0)
					put_char(pick_space());
				nterms = $urandom_range(1, 6);
				repeat (nterms) begin
					if ($urandom_range(3) == 0)
						put_char(8'($urandom_range(65, 90)));
					else
						put_char(8'($urandom_range(65, 70)));
					repeat ($urandom_range(0, SYMBOL_CHARS - 1))
						put_char(8'($urandom_range(97, 99)));
					case ($urandom_range(9))
						0, 1, 2: ;
						3: put_char("0");
						4: repeat ($urandom_range(5, 7)) put_char("9");
						default: repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(48, 57)));
					endcase
					if ($urandom_range(4) == 0)
						put_char(pick_space());
				end
			end else if (pick < 75) begin
				// distinct symbols, from two fewer to two more than there are table slots
				nterms = $urandom_range(TABLE_SLOTS - 2, TABLE_SLOTS + 2);
				for (i = 0; i < nterms; i++) begin
					put_char(8'(65 + i));
					if ($urandom_range(1))
						put_char(8'($urandom_range(97, 122)));
					if ($urandom_range(1))
						put_char(8'($urandom_range(49, 57)));
				end
			end else if (pick < 88) begin
				// good start, then one character that breaks the formula
				put_char(8'($urandom_range(65, 90)));
				case ($urandom_range(4))
					0: repeat (SYMBOL_CHARS) put_char(8'($urandom_range(97, 122)));
					1: begin
						put_char(pick_space());
						put_char(8'($urandom_range(48, 57)));
					end
					2: put_char(8'($urandom_range(128, 255)));
					3: put_char(8'($urandom_range(33, 47)));
					default: begin
						put_char(" ");
						put_char(8'($urandom_range(97, 122)));
					end
				endcase
				repeat ($urandom_range(0, 4)) put_char(8'($urandom));
			end else begin
				repeat ($urandom_range(0, 8)) put_char(8'($urandom));
			end
			w.kind = KIND_END;
			w.ch   = 8'($urandom);
			formula.push_back(w);
			foreach (formula[k])
				send_word(formula[k]);
		end
		push <= 1'b0;
		calm = 1'b0;

		while (awaited.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : drain
		out_word_t want;
		int        hold_left;
		bit        held;
		hold_left = 0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (awaited.size() == 0) begin
					report_mismatch($sformatf("word %h with nothing awaited", result));
				end else begin
					want = awaited.pop_front();
					compare_word(result, want);
				end
			end
			// one long hold so the parser backs up and stalls its input
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!held && words_in >= 300) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(99) >= 15);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
